>>> src/mctb_pkg.sv
// Package for the timer bank: widths, opcodes, FSM states and the control
// bundle handed from the controller to every timer cell. No dependencies.
package mctb_pkg;

    localparam int unsigned NUM_TIMERS_DEF = 16;
    localparam int unsigned OP_W           = 3;
    localparam int unsigned IDX_W          = 4;
    localparam int unsigned PERIOD_W       = 32;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 3'd0,
        OP_PAUSE  = 3'd1,
        OP_RESUME = 3'd2,
        OP_STOP   = 3'd3,
        OP_TICK   = 3'd4,
        OP_POLL   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    // Broadcast to all cells; shift moves the poll token one cell along.
    typedef struct packed {
        logic                cmd_en;
        t_op                 op;
        logic [IDX_W-1:0]    timer_index;
        logic [PERIOD_W-1:0] period;
        logic                repeat_mode;
        logic                shift;
    } t_cell_ctl;

endpackage

>>> src/mctb_if.sv
// Handshake interfaces for the timer bank: command requests in, expiry
// reports out. Depends on mctb_pkg for field widths.
interface mctb_req_if;
    logic                          valid;
    logic                          ready;
    logic [mctb_pkg::OP_W-1:0]     opcode;
    logic [mctb_pkg::IDX_W-1:0]    timer_index;
    logic [mctb_pkg::PERIOD_W-1:0] period;
    logic                          repeat_mode;

    modport source (output valid, opcode, timer_index, period, repeat_mode, input ready);
    modport sink   (input valid, opcode, timer_index, period, repeat_mode, output ready);
endinterface

interface mctb_res_if;
    logic                       valid;
    logic                       ready;
    logic [mctb_pkg::IDX_W-1:0] expired_timer;
    logic                       last;

    modport source (output valid, expired_timer, last, input ready);
    modport sink   (input valid, expired_timer, last, output ready);
endinterface

>>> src/mctb_cell.sv
// One timer channel: period, count and flags, plus one stage of the poll
// token chain. Depends on mctb_pkg.
module mctb_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mctb_pkg::t_cell_ctl i_ctl,
    input  logic                i_tok,
    output logic                o_tok,
    output logic                o_hit
);

    localparam bit REACH = IDX < (1 << mctb_pkg::IDX_W);
    localparam logic [mctb_pkg::IDX_W-1:0] MY_IDX = IDX[mctb_pkg::IDX_W-1:0];

    logic [mctb_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [mctb_pkg::PERIOD_W-1:0] r_count,  n_count;
    logic [mctb_pkg::PERIOD_W-1:0] dec;
    logic r_run, n_run;
    logic r_rep, n_rep;
    logic r_exp, n_exp;
    logic r_tok, n_tok;
    logic sel;

    assign sel   = REACH && i_ctl.cmd_en && (i_ctl.timer_index == MY_IDX);
    assign dec   = r_count - mctb_pkg::PERIOD_W'(1);
    assign o_tok = r_tok;
    assign o_hit = r_tok && r_exp;

    always_comb begin
        n_period = r_period;
        n_count  = r_count;
        n_run    = r_run;
        n_rep    = r_rep;
        n_exp    = r_exp;
        n_tok    = i_ctl.shift ? i_tok : r_tok;
        if (i_ctl.shift && r_tok) begin
            n_exp = 1'b0;
        end
        if (i_ctl.cmd_en) begin
            case (i_ctl.op)
                mctb_pkg::OP_START: begin
                    if (sel) begin
                        n_period = i_ctl.period;
                        n_count  = i_ctl.period;
                        n_rep    = i_ctl.repeat_mode;
                        n_exp    = (i_ctl.period == '0);
                        n_run    = (i_ctl.period != '0);
                    end
                end
                mctb_pkg::OP_PAUSE: begin
                    if (sel) n_run = 1'b0;
                end
                mctb_pkg::OP_RESUME: begin
                    if (sel) n_run = 1'b1;
                end
                mctb_pkg::OP_STOP: begin
                    if (sel) begin
                        n_run   = 1'b0;
                        n_count = '0;
                    end
                end
                mctb_pkg::OP_TICK: begin
                    if (r_run && r_count != '0) begin
                        if (dec == '0) begin
                            n_exp = 1'b1;
                            if (r_rep) begin
                                n_count = r_period;
                            end else begin
                                n_count = '0;
                                n_run   = 1'b0;
                            end
                        end else begin
                            n_count = dec;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_count  <= '0;
            r_run    <= 1'b0;
            r_rep    <= 1'b0;
            r_exp    <= 1'b0;
            r_tok    <= 1'b0;
        end else begin
            r_period <= n_period;
            r_count  <= n_count;
            r_run    <= n_run;
            r_rep    <= n_rep;
            r_exp    <= n_exp;
            r_tok    <= n_tok;
        end
    end

endmodule

>>> src/multi_channel_timer_bank_core.sv
// Timer bank top level: command decode, poll sequencer and result register
// around a chain of mctb_cell. Depends on mctb_pkg, mctb_if, mctb_cell.

// Start, pause, resume and stop update the addressed channel cell, and tick
// updates every cell, in the cycle the request is accepted. A poll walks a
// token down the cell chain, one channel per cycle while the result side
// does not stall, and holds the request side off until scan and flush end.
// Expired channels come out in ascending order, one per cycle at most, the
// last of a poll flagged; a poll with nothing expired gives nothing.
module multi_channel_timer_bank_core #(
    parameter int unsigned NUM_TIMERS = mctb_pkg::NUM_TIMERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mctb_req_if.sink   i_req,
    mctb_res_if.source o_res
);

    localparam int unsigned CW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    mctb_pkg::t_state    r_state, n_state;
    mctb_pkg::t_cell_ctl ctl;
    mctb_pkg::t_op       op;

    logic [CW-1:0]               r_cnt, n_cnt;
    logic [mctb_pkg::IDX_W-1:0]  r_held, n_held;
    logic                        r_held_v, n_held_v;
    logic [mctb_pkg::IDX_W-1:0]  r_out_idx, n_out_idx;
    logic                        r_out_last, n_out_last;
    logic                        r_out_v, n_out_v;

    logic [NUM_TIMERS:0]   tok_chain;
    logic [NUM_TIMERS-1:0] hit_vec;
    logic req_acc, poll_acc, hit, out_free, blocked, adv, push_mid, push_end, at_end;

    assign op       = mctb_pkg::t_op'(i_req.opcode);
    assign req_acc  = i_req.valid && i_req.ready;
    assign poll_acc = req_acc && (op == mctb_pkg::OP_POLL);
    assign hit      = |hit_vec;
    assign out_free = !r_out_v || o_res.ready;
    assign blocked  = hit && r_held_v && !out_free;
    assign adv      = (r_state == mctb_pkg::ST_SCAN) && !blocked;
    assign push_mid = adv && hit && r_held_v;
    assign push_end = (r_state == mctb_pkg::ST_FLUSH) && r_held_v && out_free;
    assign at_end   = (r_cnt == CW'(NUM_TIMERS - 1));

    assign i_req.ready       = (r_state == mctb_pkg::ST_IDLE);
    assign o_res.valid       = r_out_v;
    assign o_res.expired_timer = r_out_idx;
    assign o_res.last        = r_out_last;

    assign ctl.cmd_en      = req_acc && (op != mctb_pkg::OP_POLL);
    assign ctl.op          = op;
    assign ctl.timer_index = i_req.timer_index;
    assign ctl.period      = i_req.period;
    assign ctl.repeat_mode = i_req.repeat_mode;
    assign ctl.shift       = poll_acc || adv;

    assign tok_chain[0] = poll_acc;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        mctb_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_tok   (tok_chain[g]),
            .o_tok   (tok_chain[g+1]),
            .o_hit   (hit_vec[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_held     = r_held;
        n_held_v   = r_held_v;
        n_out_idx  = r_out_idx;
        n_out_last = r_out_last;
        n_out_v    = r_out_v && !o_res.ready;
        case (r_state)
            mctb_pkg::ST_IDLE: begin
                if (poll_acc) begin
                    n_cnt   = '0;
                    n_state = mctb_pkg::ST_SCAN;
                end
            end
            mctb_pkg::ST_SCAN: begin
                if (adv) begin
                    if (hit) begin
                        n_held   = mctb_pkg::IDX_W'(r_cnt);
                        n_held_v = 1'b1;
                    end
                    if (push_mid) begin
                        n_out_idx  = r_held;
                        n_out_last = 1'b0;
                        n_out_v    = 1'b1;
                    end
                    n_cnt = r_cnt + CW'(1);
                    if (at_end) n_state = mctb_pkg::ST_FLUSH;
                end
            end
            mctb_pkg::ST_FLUSH: begin
                if (push_end) begin
                    n_out_idx  = r_held;
                    n_out_last = 1'b1;
                    n_out_v    = 1'b1;
                    n_held_v   = 1'b0;
                end
                if (!r_held_v || out_free) n_state = mctb_pkg::ST_IDLE;
            end
            default: begin
                n_state = mctb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mctb_pkg::ST_IDLE;
            r_held_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_held_v <= n_held_v;
            r_out_v  <= n_out_v;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    // exactly one cell holds the token while scanning, none otherwise
    a_tok_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctb_pkg::ST_SCAN) |-> $onehot(tok_chain[NUM_TIMERS:1]))
        else $error("poll token not one-hot during scan");

    a_tok_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctb_pkg::ST_IDLE) |-> (tok_chain[NUM_TIMERS:1] == '0))
        else $error("poll token left in chain");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_mid || push_end) |-> out_free)
        else $error("result register overwritten");

    a_held_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mctb_pkg::ST_IDLE) |-> !r_held_v)
        else $error("held result lost at end of poll");

endmodule

>>> dv/mctb_expiry_checker.sv
// Checker for the timer bank: mirrors each channel's period, count and flags
// from accepted requests and compares every expiry report in order.
// Depends on mctb_pkg and mctb_if.
module mctb_expiry_checker #(
    parameter int unsigned NUM_TIMERS = mctb_pkg::NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mctb_req_if         i_req,
    mctb_res_if         i_res,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_REPORTS = 16;
    localparam int unsigned SHOWN_FAILS = 10;

    typedef struct packed {
        logic [mctb_pkg::IDX_W-1:0] timer;
        logic                       last;
    } t_report;

    logic [mctb_pkg::PERIOD_W-1:0] reload_period [NUM_TIMERS];
    logic [mctb_pkg::PERIOD_W-1:0] count_left    [NUM_TIMERS];
    logic                          running       [NUM_TIMERS];
    logic                          periodic      [NUM_TIMERS];
    logic                          expired       [NUM_TIMERS];

    t_report     due_reports [$];
    int unsigned fails = 0;

    function automatic void clear_bank();
        for (int ch = 0; ch < NUM_TIMERS; ch++) begin
            reload_period[ch] = '0;
            count_left[ch]    = '0;
            running[ch]       = 1'b0;
            periodic[ch]      = 1'b0;
            expired[ch]       = 1'b0;
        end
        due_reports.delete();
    endfunction

    function automatic void advance_tick();
        for (int ch = 0; ch < NUM_TIMERS; ch++) begin
            if (running[ch] && count_left[ch] != '0) begin
                count_left[ch] = count_left[ch] - 1'b1;
                if (count_left[ch] == '0) begin
                    expired[ch] = 1'b1;
                    if (periodic[ch]) begin
                        count_left[ch] = reload_period[ch];
                    end else begin
                        running[ch] = 1'b0;
                    end
                end
            end
        end
    endfunction

    function automatic void collect_expired();
        logic [mctb_pkg::IDX_W-1:0] hits [$];
        for (int ch = 0; ch < NUM_TIMERS && hits.size() < MAX_REPORTS; ch++) begin
            if (expired[ch]) begin
                expired[ch] = 1'b0;
                hits.push_back(mctb_pkg::IDX_W'(ch));
            end
        end
        foreach (hits[i]) begin
            due_reports.push_back('{hits[i], i == hits.size() - 1});
        end
    endfunction

    function automatic void apply_request(
        logic [mctb_pkg::OP_W-1:0]     op,
        logic [mctb_pkg::IDX_W-1:0]    idx,
        logic [mctb_pkg::PERIOD_W-1:0] per,
        logic                          rep
    );
        logic in_range;
        in_range = idx < NUM_TIMERS;
        case (op)
            mctb_pkg::OP_START: begin
                if (in_range) begin
                    reload_period[idx] = per;
                    count_left[idx]    = per;
                    periodic[idx]      = rep;
                    expired[idx]       = (per == '0);
                    running[idx]       = (per != '0);
                end
            end
            mctb_pkg::OP_PAUSE: begin
                if (in_range) running[idx] = 1'b0;
            end
            mctb_pkg::OP_RESUME: begin
                if (in_range) running[idx] = 1'b1;
            end
            mctb_pkg::OP_STOP: begin
                if (in_range) begin
                    running[idx]    = 1'b0;
                    count_left[idx] = '0;
                end
            end
            mctb_pkg::OP_TICK:  advance_tick();
            mctb_pkg::OP_POLL:  collect_expired();
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            clear_bank();
        end else begin
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.opcode, i_req.timer_index, i_req.period,
                              i_req.repeat_mode);
            end
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.expired_timer, i_res.last};
                if (due_reports.size() == 0) begin
                    fails++;
                    if (fails <= SHOWN_FAILS) begin
                        $display("ERROR %0t: unexpected report timer=%0d last=%0b",
                                 $realtime, got.timer, got.last);
                    end
                end else begin
                    want = due_reports.pop_front();
                    if (got.timer !== want.timer || got.last !== want.last) begin
                        fails++;
                        if (fails <= SHOWN_FAILS) begin
                            $display("ERROR %0t: expected %0d/%0b, got %0d/%0b",
                                     $realtime, want.timer, want.last,
                                     got.timer, got.last);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_reports.size();
    end

endmodule

>>> dv/tb_multi_channel_timer_bank_core.sv
// Testbench top for the timer bank: clock, reset, command requests sent in
// bursts with gaps, result-side stalls and the verdict. Depends on mctb_pkg,
// mctb_if, multi_channel_timer_bank_core and mctb_expiry_checker.
module tb_multi_channel_timer_bank_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_TIMERS    = mctb_pkg::NUM_TIMERS_DEF;
    localparam int unsigned RANDOM_REQS   = 100;
    localparam int unsigned SETTLE_CYCLES = 4 * NUM_TIMERS + 8;
    localparam logic [mctb_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [mctb_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned burst_left = 0;
    int unsigned sent = 0;

    mctb_req_if req_if();
    mctb_res_if res_if();

    multi_channel_timer_bank_core #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    mctb_expiry_checker #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    task automatic send_req(
        input logic [mctb_pkg::OP_W-1:0]     op,
        input logic [mctb_pkg::IDX_W-1:0]    idx,
        input logic [mctb_pkg::PERIOD_W-1:0] per,
        input logic                          rep
    );
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.timer_index <= idx;
        req_if.period      <= per;
        req_if.repeat_mode <= rep;
        do @(posedge clk); while (!req_if.ready);
        burst_left--;
        if (op != OP_SPARE_A && op != OP_SPARE_B) sent++;
    endtask

    // any opcode with random index, period and mode
    task automatic send_rand(input logic [mctb_pkg::OP_W-1:0] op);
        send_req(op, mctb_pkg::IDX_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [mctb_pkg::PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $urandom;
            2:       return '1;
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // every channel expires within two ticks, so the poll reports all of them
    task automatic expire_all();
        for (int ch = 0; ch < NUM_TIMERS; ch++) begin
            send_req(mctb_pkg::OP_START, mctb_pkg::IDX_W'(ch), $urandom_range(1, 2),
                     1'($urandom_range(0, 1)));
        end
        send_rand(mctb_pkg::OP_TICK);
        send_rand(mctb_pkg::OP_TICK);
        send_rand(mctb_pkg::OP_POLL);
    endtask

    initial begin
        res_if.ready <= 1'b0;
        forever begin : stall_pattern
            int unsigned mode;
            int unsigned phase_left;
            @(posedge clk);
            if (phase_left == 0) begin
                mode       = $urandom_range(0, 2);
                phase_left = $urandom_range(8, 64);
            end
            phase_left--;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned pick;
        req_if.valid       <= 1'b0;
        req_if.opcode      <= '0;
        req_if.timer_index <= '0;
        req_if.period      <= '0;
        req_if.repeat_mode <= 1'b0;
        rst_n              <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_req(mctb_pkg::OP_POLL,   4'd0,  '0,            1'b0);  // nothing expired
        send_req(mctb_pkg::OP_START,  4'd0,  '0,            1'b0);  // zero period
        send_req(mctb_pkg::OP_START,  4'd15, '0,            1'b1);  // periodic, zero period
        send_req(mctb_pkg::OP_START,  4'd1,  32'd1,         1'b0);
        send_req(mctb_pkg::OP_START,  4'd2,  32'd2,         1'b1);
        send_req(mctb_pkg::OP_START,  4'd3,  32'hFFFF_FFFF, 1'b1);
        send_req(mctb_pkg::OP_START,  4'd4,  32'd3,         1'b0);
        send_req(mctb_pkg::OP_PAUSE,  4'd4,  '0,            1'b0);
        send_req(mctb_pkg::OP_STOP,   4'd3,  '0,            1'b0);
        send_req(mctb_pkg::OP_RESUME, 4'd3,  '0,            1'b0);  // runs on a zero count
        send_req(mctb_pkg::OP_TICK,   4'd0,  32'h5555_5555, 1'b1);
        send_req(mctb_pkg::OP_TICK,   4'd15, 32'hAAAA_AAAA, 1'b0);
        send_req(OP_SPARE_A,          4'd5,  32'h0000_0001, 1'b1);
        send_req(OP_SPARE_B,          4'd6,  32'h8000_0000, 1'b0);
        send_req(mctb_pkg::OP_POLL,   4'd9,  '0,            1'b1);
        send_req(mctb_pkg::OP_RESUME, 4'd4,  '0,            1'b0);
        send_req(mctb_pkg::OP_TICK,   4'd0,  '0,            1'b0);
        send_req(mctb_pkg::OP_TICK,   4'd0,  '0,            1'b0);
        send_req(mctb_pkg::OP_TICK,   4'd0,  '0,            1'b0);
        send_req(mctb_pkg::OP_POLL,   4'd0,  '0,            1'b0);
        send_req(mctb_pkg::OP_START,  4'd5,  32'hAAAA_AAAA, 1'b0);
        send_req(mctb_pkg::OP_START,  4'd6,  32'h5555_5555, 1'b1);
        send_req(mctb_pkg::OP_POLL,   4'd15, '1,            1'b1);
        wait_drained();

        sent = 0;
        expire_all();
        while (sent < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                expire_all();
            end else if (pick < 7) begin
                send_rand($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B);
            end else if (pick < 35) begin
                send_req(mctb_pkg::OP_START, mctb_pkg::IDX_W'($urandom), pick_period(),
                         1'($urandom_range(0, 1)));
            end else if (pick < 65) begin
                send_rand(mctb_pkg::OP_TICK);
            end else if (pick < 80) begin
                send_rand(mctb_pkg::OP_POLL);
            end else if (pick < 87) begin
                send_rand(mctb_pkg::OP_PAUSE);
            end else if (pick < 93) begin
                send_rand(mctb_pkg::OP_RESUME);
            end else begin
                send_rand(mctb_pkg::OP_STOP);
            end
            if ($urandom_range(0, 39) == 0) wait_drained();
        end
        send_req(mctb_pkg::OP_POLL, '0, '0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
